[hw/rtl/bbl_pkg.sv]
// Shared constants, types and codes of the box blur line filter.
`default_nettype none

package bbl_pkg;

    localparam int LINE_MAX  = 4096;
    localparam int ADDR_W    = $clog2(LINE_MAX);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int RAD_W     = 6;
    localparam int DIAM_W    = RAD_W + 1;
    localparam int CH_W      = 8;
    localparam int NUM_LANES = 4;
    localparam int PIX_W     = CH_W * NUM_LANES;
    localparam int QBITS     = CH_W;
    localparam int SUM_W     = CH_W + DIAM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RECALC
    } t_state;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADD,
        OP_SLIDE
    } t_op_kind;

    typedef struct packed {
        logic line_end;
        logic run_last;
        logic overflow;
    } t_flags;

    typedef struct packed {
        logic     valid;
        t_op_kind kind;
        logic     emit;
        t_flags   flags;
    } t_op;

endpackage

`default_nettype wire

[hw/rtl/bbl_in_if.sv]
// Input pixel channel of the box blur line filter.
`default_nettype none

interface bbl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_alpha;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       line_end;

    modport source (
        output valid, in_alpha, in_red, in_green, in_blue, line_end,
        input  ready
    );

    modport sink (
        input  valid, in_alpha, in_red, in_green, in_blue, line_end,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/bbl_out_if.sv]
// Output pixel channel of the box blur line filter.
`default_nettype none

interface bbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_line_end;
    logic       run_last;
    logic       line_overflow;

    modport source (
        output valid, out_alpha, out_red, out_green, out_blue, out_line_end,
               run_last, line_overflow,
        input  ready
    );

    modport sink (
        input  valid, out_alpha, out_red, out_green, out_blue, out_line_end,
               run_last, line_overflow,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/bbl_seq.sv]
// Line store and window sequencer: stores pixels and issues window read operations.
`default_nettype none

module bbl_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic [bbl_pkg::RAD_W-1:0]   i_radius,
    bbl_in_if.sink                           i_pix,
    output bbl_pkg::t_op                     o_op,
    output logic [bbl_pkg::PIX_W-1:0]        o_add_pix,
    output logic [bbl_pkg::PIX_W-1:0]        o_sub_pix
);
    import bbl_pkg::*;

    logic [PIX_W-1:0]  r_mem [LINE_MAX];
    logic [PIX_W-1:0]  r_rd_add;
    logic [PIX_W-1:0]  r_rd_sub;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_wc;
    logic [CNT_W-1:0]  r_ep;
    logic              r_ovf;
    logic              r_end;
    logic              r_sum_ok;
    logic [RAD_W-1:0]  r_sum_rad;
    logic [DIAM_W-1:0] r_k;
    t_op               r_op;
    t_op               n_op;

    logic              w_accept;
    logic [CNT_W-1:0]  w_wc_m1;
    logic [ADDR_W-1:0] w_last;
    logic [CNT_W:0]    w_last_x;
    logic [CNT_W:0]    w_rad_x;
    logic [CNT_W:0]    w_ep_r;
    logic [CNT_W-1:0]  w_ep_n;
    logic [CNT_W:0]    w_epn_r;
    logic              w_cond;
    logic              w_more;
    logic              w_slide_ok;
    logic [ADDR_W-1:0] w_slide_add;
    logic [CNT_W-1:0]  w_sub_t;
    logic [ADDR_W-1:0] w_slide_sub;
    logic [CNT_W:0]    w_t;
    logic [CNT_W:0]    w_u;
    logic [ADDR_W-1:0] w_recalc_addr;
    logic [DIAM_W-1:0] w_two_r;
    logic              w_k_done;
    logic              w_issue_slide;
    logic              w_issue_recalc;
    logic              w_emit;
    logic              w_item_done;
    logic [ADDR_W-1:0] w_add_addr;

    assign w_accept = i_pix.valid && i_pix.ready;

    assign w_wc_m1  = r_wc - CNT_W'(1);
    assign w_last   = w_wc_m1[ADDR_W-1:0];
    assign w_last_x = (CNT_W+1)'(w_last);
    assign w_rad_x  = (CNT_W+1)'(i_radius);

    assign w_ep_r  = {1'b0, r_ep} + w_rad_x;
    assign w_cond  = (r_ep < r_wc) && (r_end || (w_ep_r <= w_last_x));
    assign w_ep_n  = r_ep + CNT_W'(1);
    assign w_epn_r = {1'b0, w_ep_n} + w_rad_x;
    assign w_more  = (w_ep_n < r_wc) && (r_end || (w_epn_r <= w_last_x));

    assign w_slide_ok  = r_sum_ok && (r_sum_rad == i_radius);
    assign w_slide_add = (w_ep_r > w_last_x) ? w_last : w_ep_r[ADDR_W-1:0];
    assign w_sub_t     = r_ep - CNT_W'(i_radius) - CNT_W'(1);
    assign w_slide_sub = (r_ep <= CNT_W'(i_radius)) ? '0 : w_sub_t[ADDR_W-1:0];

    assign w_t = {1'b0, r_ep} + (CNT_W+1)'(r_k);
    assign w_u = w_t - w_rad_x;
    assign w_recalc_addr = (w_t < w_rad_x)    ? '0 :
                           (w_u > w_last_x)   ? w_last : w_u[ADDR_W-1:0];

    assign w_two_r  = {i_radius, 1'b0};
    assign w_k_done = (r_k == w_two_r);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_cond) begin
                    n_state = S_IDLE;
                end else if (!w_slide_ok) begin
                    n_state = S_RECALC;
                end else if (i_adv && !w_more) begin
                    n_state = S_IDLE;
                end
            end
            S_RECALC: begin
                if (i_adv && w_k_done) begin
                    n_state = w_more ? S_CHECK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_issue_slide  = (r_state == S_CHECK) && w_cond && w_slide_ok && i_adv;
        w_issue_recalc = (r_state == S_RECALC) && i_adv;
        w_emit         = w_issue_slide || (w_issue_recalc && w_k_done);
        w_item_done    = ((r_state == S_CHECK) && !w_cond) || (w_emit && !w_more);
        w_add_addr     = w_issue_slide ? w_slide_add : w_recalc_addr;

        n_op.valid = w_issue_slide || w_issue_recalc;
        if (w_issue_slide) begin
            n_op.kind = OP_SLIDE;
        end else if (r_k == '0) begin
            n_op.kind = OP_LOAD;
        end else begin
            n_op.kind = OP_ADD;
        end
        n_op.emit           = w_emit;
        n_op.flags.line_end = r_end && !w_more;
        n_op.flags.run_last = !w_more;
        n_op.flags.overflow = r_ovf;
    end

    assign i_pix.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wc     <= '0;
            r_ep     <= '0;
            r_ovf    <= 1'b0;
            r_end    <= 1'b0;
            r_sum_ok <= 1'b0;
            r_k      <= '0;
            r_op     <= '0;
        end else begin
            r_state <= n_state;
            if (w_item_done && r_end) begin
                r_wc     <= '0;
                r_ep     <= '0;
                r_ovf    <= 1'b0;
                r_sum_ok <= 1'b0;
            end else begin
                if (w_accept) begin
                    r_end <= i_pix.line_end;
                    if (!r_wc[ADDR_W]) begin
                        r_wc <= r_wc + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                if (w_emit) begin
                    r_ep     <= w_ep_n;
                    r_sum_ok <= 1'b1;
                end
            end
            if ((r_state == S_CHECK) && w_cond && !w_slide_ok) begin
                r_k <= '0;
            end else if (w_issue_recalc) begin
                r_k <= r_k + DIAM_W'(1);
            end
            if (i_adv) begin
                r_op <= n_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sum_rad <= i_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !r_wc[ADDR_W]) begin
            r_mem[r_wc[ADDR_W-1:0]] <= {i_pix.in_alpha, i_pix.in_red,
                                        i_pix.in_green, i_pix.in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_op.valid) begin
            r_rd_add <= r_mem[w_add_addr];
            r_rd_sub <= r_mem[w_slide_sub];
        end
    end

    assign o_op      = r_op;
    assign o_add_pix = r_rd_add;
    assign o_sub_pix = r_rd_sub;

endmodule

`default_nettype wire

[hw/rtl/bbl_lane.sv]
// One channel lane: window sum accumulator followed by a pipelined divider.
`default_nettype none

module bbl_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_adv,
    input  wire bbl_pkg::t_op                i_op,
    input  wire logic [bbl_pkg::CH_W-1:0]    i_add,
    input  wire logic [bbl_pkg::CH_W-1:0]    i_sub,
    input  wire logic [bbl_pkg::DIAM_W-1:0]  i_diam,
    output logic [bbl_pkg::CH_W-1:0]         o_quot
);
    import bbl_pkg::*;

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] n_acc;
    logic [SUM_W-1:0] r_rem [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic [SUM_W-1:0] n_rem [QBITS];
    logic [QBITS-1:0] n_q   [QBITS];
    logic [SUM_W-1:0] w_trial [QBITS];

    always_comb begin
        case (i_op.kind)
            OP_LOAD:  n_acc = SUM_W'(i_add);
            OP_ADD:   n_acc = r_acc + SUM_W'(i_add);
            OP_SLIDE: n_acc = r_acc + SUM_W'(i_add) - SUM_W'(i_sub);
            default:  n_acc = r_acc;
        endcase
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb begin
        for (int j = 0; j < QBITS; j++) begin
            w_trial[j] = SUM_W'(i_diam) << (QBITS - 1 - j);
            if (r_rem[j] >= w_trial[j]) begin
                n_rem[j] = r_rem[j] - w_trial[j];
                n_q[j]   = r_q[j] | (QBITS'(1) << (QBITS - 1 - j));
            end else begin
                n_rem[j] = r_rem[j];
                n_q[j]   = r_q[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_op.valid) begin
                r_acc <= n_acc;
            end
            r_rem[0] <= n_acc;
            r_q[0]   <= '0;
            for (int j = 0; j < QBITS; j++) begin
                r_rem[j+1] <= n_rem[j];
                r_q[j+1]   <= n_q[j];
            end
        end
    end

    assign o_quot = r_q[QBITS];

endmodule

`default_nettype wire

[hw/rtl/bbl_merge.sv]
// Merge stage: aligns result flags with the lanes and holds the output register.
`default_nettype none

module bbl_merge (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire bbl_pkg::t_op             i_op,
    input  wire logic [bbl_pkg::CH_W-1:0] i_quot [bbl_pkg::NUM_LANES],
    bbl_out_if.source                     o_pix,
    output logic                          o_adv
);
    import bbl_pkg::*;

    logic             r_vld [QBITS+1];
    t_flags           r_flg [QBITS+1];
    logic             r_out_valid;
    t_flags           r_out_flg;
    logic [CH_W-1:0]  r_out_ch [NUM_LANES];

    assign o_adv = !r_out_valid || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QBITS; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_vld[0] <= i_op.valid && i_op.emit;
            for (int j = 0; j < QBITS; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
            r_out_valid <= r_vld[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_flg[0] <= i_op.flags;
            for (int j = 0; j < QBITS; j++) begin
                r_flg[j+1] <= r_flg[j];
            end
            r_out_flg <= r_flg[QBITS];
            for (int c = 0; c < NUM_LANES; c++) begin
                r_out_ch[c] <= i_quot[c];
            end
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.out_alpha     = r_out_ch[0];
    assign o_pix.out_red       = r_out_ch[1];
    assign o_pix.out_green     = r_out_ch[2];
    assign o_pix.out_blue      = r_out_ch[3];
    assign o_pix.out_line_end  = r_out_flg.line_end;
    assign o_pix.run_last      = r_out_flg.run_last;
    assign o_pix.line_overflow = r_out_flg.overflow;

endmodule

`default_nettype wire

[hw/rtl/box_blur_line_filter.sv]
// Top level of the box blur line filter: radius register, sequencer, lanes and merge.
//
//  Channel   Direction  Transaction
//  i_pix     in         one ARGB pixel with its line end mark
//  o_pix     out        one blurred ARGB pixel with line end, run end and overflow marks
//  i_cfg_*   in         write of the window radius, no handshake
//
// A pixel is accepted in the idle state and then checked for released outputs; each blurred
// pixel it releases is issued as one window operation that reads both line store read ports.
// The first output of a line, and the first after a radius change, rebuilds the window sums
// instead, with one load and 2*radius add operations. A result then passes the operation
// register, the divider input register, the divider stages and the output register to o_pix.
// Reset clears the line state and sets the radius to 1; the line store is not cleared.
// A stall on o_pix freezes the read, sum and divide pipeline and the sequencer's issue;
// i_pix is ready only while the sequencer is idle.
`default_nettype none

module box_blur_line_filter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bbl_pkg::RAD_W-1:0]  i_cfg_wdata,
    bbl_in_if.sink                          i_pix,
    bbl_out_if.source                       o_pix
);
    import bbl_pkg::*;

    logic [RAD_W-1:0]  r_radius;
    logic [DIAM_W-1:0] w_diam;
    logic              w_adv;
    t_op               w_op;
    logic [PIX_W-1:0]  w_add_pix;
    logic [PIX_W-1:0]  w_sub_pix;
    logic [CH_W-1:0]   w_quot [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    assign w_diam = {r_radius, 1'b1};

    bbl_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_radius  (r_radius),
        .i_pix     (i_pix),
        .o_op      (w_op),
        .o_add_pix (w_add_pix),
        .o_sub_pix (w_sub_pix)
    );

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        bbl_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_op   (w_op),
            .i_add  (w_add_pix[CH_W*(NUM_LANES-1-c) +: CH_W]),
            .i_sub  (w_sub_pix[CH_W*(NUM_LANES-1-c) +: CH_W]),
            .i_diam (w_diam),
            .o_quot (w_quot[c])
        );
    end

    bbl_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_quot  (w_quot),
        .o_pix   (o_pix),
        .o_adv   (w_adv)
    );

endmodule

`default_nettype wire
